FILE: rtl/core/image_chunk_framer_unit_macros.svh
// ----------------------------------------------------------------------------
// image chunk framer assertion macros
// shared property forms for the framer checks
// ----------------------------------------------------------------------------
`ifndef IMAGE_CHUNK_FRAMER_UNIT_MACROS_SVH
`define IMAGE_CHUNK_FRAMER_UNIT_MACROS_SVH

// same-cycle implication under reset
`define ICF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define ICF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg
// types and constants shared by the image chunk framer modules
// ----------------------------------------------------------------------------
package icf_pkg;

	localparam logic [5:0]  CHUNK_BYTES   = 6'd60;
	localparam logic [15:0] POS_STEP      = {10'd0, CHUNK_BYTES};
	localparam logic [7:0]  MARKER_RESET  = 8'h43;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// one classified input transaction
	typedef struct packed {
		logic [7:0]  data;
		logic [7:0]  marker;
		logic [15:0] pos;
		logic        hdr;
		logic        eoc;
	} icf_cmd_t;

	typedef struct packed {
		logic     push;
		icf_cmd_t cmd;
	} icf_push_t;

	typedef struct packed {
		logic     valid;
		logic     full;
		icf_cmd_t cmd;
	} icf_head_t;

	typedef enum logic [2:0] {
		PH_MARK,
		PH_POSH,
		PH_POSL,
		PH_DATA,
		PH_SUM
	} icf_phase_t;

endpackage

FILE: rtl/core/image_chunk_framer_unit.sv
// ----------------------------------------------------------------------------
// image_chunk_framer_unit
// packs image bytes into 64-byte frames with header and checksum
// ----------------------------------------------------------------------------
// Each input byte yields one to four output bytes: marker, position high and
// low before the first byte of a chunk, the byte itself, and the checksum
// after the sixtieth. The front part takes one input transaction per cycle,
// while the queue has room, into a four-entry command queue; the back part
// sends one frame byte per cycle while m_tready allows, so the output side
// sets the rate, with 64 frame bytes per 60 input bytes. Restart on s_tuser
// ends any partial frame without a checksum and rewinds the position to zero.
// ----------------------------------------------------------------------------
`include "image_chunk_framer_unit_macros.svh"

module image_chunk_framer_unit
	import icf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] image_byte
	input  logic [0:0] s_tuser,    // [0] restart_image
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] frame_byte
	output logic       m_tlast,    // end_of_frame
	output logic [0:0] m_tuser,    // [0] last_of_run
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data    // [7:0] start_marker
);

	logic [7:0] start_marker_q;
	icf_push_t  push;
	icf_head_t  head;
	logic       pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= MARKER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			start_marker_q <= cfg_data;
		end
	end

	icf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.start_marker (start_marker_q),
		.q_full       (head.full),
		.push         (push)
	);

	icf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head)
	);

	icf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	`ICF_ASSERT_IMP(a_eof_is_last, m_tvalid && m_tlast, m_tuser[0], "checksum byte not last of run")
	`ICF_ASSERT_IMP(a_pop_has_head, pop, head.valid, "command popped from empty queue")
	`ICF_ASSERT_IMP(a_push_has_room, push.push, !head.full, "command pushed into full queue")
	`ICF_ASSERT_NXT(a_push_fills, push.push && !pop, head.valid, "pushed command not visible")

endmodule

FILE: rtl/core/icf_front.sv
// ----------------------------------------------------------------------------
// icf_front
// accepts image bytes, tracks chunk position and count, emits commands
// ----------------------------------------------------------------------------
module icf_front
	import icf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // [7:0] image_byte
	input  logic [0:0]  s_tuser,      // [0] restart_image
	input  logic [7:0]  start_marker,
	input  logic        q_full,
	output icf_push_t   push
);

	logic [15:0] pos_q;
	logic [5:0]  cnt_q;
	logic [15:0] pos_base;
	logic [5:0]  cnt_base;
	logic [5:0]  cnt_inc;
	logic        eoc;
	logic        take;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	// restart drops any partial chunk and rewinds the position
	assign pos_base = s_tuser[0] ? '0 : pos_q;
	assign cnt_base = s_tuser[0] ? '0 : cnt_q;
	assign cnt_inc  = cnt_base + 6'd1;
	assign eoc      = (cnt_inc >= CHUNK_BYTES);

	always_comb begin
		push.push       = take;
		push.cmd.data   = s_tdata;
		push.cmd.marker = start_marker;
		push.cmd.pos    = pos_base;
		push.cmd.hdr    = (cnt_base == '0);
		push.cmd.eoc    = eoc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (eoc) begin
				pos_q <= pos_base + POS_STEP;
				cnt_q <= '0;
			end else begin
				pos_q <= pos_base;
				cnt_q <= cnt_inc;
			end
		end
	end

endmodule

FILE: rtl/core/icf_queue.sv
// ----------------------------------------------------------------------------
// icf_queue
// short command fifo between the front and back parts
// ----------------------------------------------------------------------------
module icf_queue
	import icf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  icf_push_t push,
	input  logic      pop,
	output icf_head_t head
);

	icf_cmd_t       mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign do_push = push.push && (count_q != QDEPTH[QAW:0]);
	assign do_pop  = pop && (count_q != '0);

	always_comb begin
		head.valid = (count_q != '0);
		head.full  = (count_q == QDEPTH[QAW:0]);
		head.cmd   = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/icf_back.sv
// ----------------------------------------------------------------------------
// icf_back
// expands each command into frame bytes and keeps the running checksum
// ----------------------------------------------------------------------------
module icf_back
	import icf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  icf_head_t  head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] frame_byte
	output logic       m_tlast,   // end_of_frame
	output logic [0:0] m_tuser    // [0] last_of_run
);

	icf_phase_t phase_q;
	icf_phase_t phase_nxt;
	icf_phase_t cur;
	logic       started_q;
	logic       started_nxt;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_eof_q;
	logic       out_last_q;
	logic [7:0] sum_q;
	logic       load;
	logic       emit;
	logic       done;
	logic [7:0] byte_c;
	logic       eof_c;

	assign load = !out_valid_q || m_tready;
	assign emit = head.valid && load;
	assign pop  = emit && done;

	always_comb begin
		cur         = started_q ? phase_q : (head.cmd.hdr ? PH_MARK : PH_DATA);
		phase_nxt   = phase_q;
		started_nxt = started_q;
		byte_c      = head.cmd.data;
		eof_c       = 1'b0;
		done        = 1'b0;
		case (cur)
			PH_MARK: begin
				byte_c    = head.cmd.marker;
				phase_nxt = PH_POSH;
			end
			PH_POSH: begin
				byte_c    = head.cmd.pos[15:8];
				phase_nxt = PH_POSL;
			end
			PH_POSL: begin
				byte_c    = head.cmd.pos[7:0];
				phase_nxt = PH_DATA;
			end
			PH_DATA: begin
				byte_c    = head.cmd.data;
				phase_nxt = PH_SUM;
				done      = !head.cmd.eoc;
			end
			PH_SUM: begin
				byte_c    = sum_q;
				eof_c     = 1'b1;
				done      = 1'b1;
			end
			default: begin
				done      = 1'b1;
			end
		endcase
		if (emit) begin
			started_nxt = !done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MARK;
			started_q <= 1'b0;
		end else begin
			started_q <= started_nxt;
			if (emit) begin
				phase_q <= phase_nxt;
			end
		end
	end

	// the marker byte restarts the checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (emit) begin
			if (cur == PH_MARK) begin
				sum_q <= byte_c;
			end else begin
				sum_q <= sum_q + byte_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_c;
			out_eof_q  <= eof_c;
			out_last_q <= done;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_byte_q;
	assign m_tlast    = out_eof_q;
	assign m_tuser[0] = out_last_q;

endmodule
